### hdl/bll_pkg.sv
// Package for the bounded list block: opcodes, status codes, FSM states
// and the control word broadcast along the cell chain. No dependencies.
package bll_pkg;

  // Count/index width in the control word; covers DEPTH up to 127.
  localparam int CNT_W = 7;
  localparam int VAL_W = 32;

  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_BACK  = 2'd1,
    OP_REMOVE     = 2'd2,
    OP_NOP        = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    STS_DONE  = 2'd0,
    STS_RANGE = 2'd1,
    STS_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EMIT = 1'b1
  } state_t;

  typedef enum logic [2:0] {
    CELL_HOLD       = 3'd0,
    CELL_PUSH_FRONT = 3'd1,
    CELL_PUSH_BACK  = 3'd2,
    CELL_REMOVE     = 3'd3,
    CELL_ROTATE     = 3'd4
  } cell_op_t;

  // Broadcast to every cell each cycle.
  typedef struct packed {
    cell_op_t               kind;
    logic [VAL_W-1:0]       value;   // value being pushed
    logic [CNT_W-1:0]       wr_idx;  // current count: tail write slot
    logic [CNT_W-1:0]       rm_fwd;  // remove position, forward chain
    logic [CNT_W-1:0]       rm_rev;  // remove position, reversed chain
    logic [CNT_W-1:0]       wrap;    // count-1: slot that takes the head on rotate
  } cell_ctrl_t;

endpackage

### hdl/bll_cell.sv
// One cell of the list chain: holds one forward and one reversed element.
// Depends on bll_pkg for the control word.
module bll_cell #(
  parameter int POS = 0
) (
  input  logic                       clk,
  input  bll_pkg::cell_ctrl_t        ctrl,
  input  logic [bll_pkg::VAL_W-1:0]  fwd_left,
  input  logic [bll_pkg::VAL_W-1:0]  fwd_right,
  input  logic [bll_pkg::VAL_W-1:0]  fwd_head,
  input  logic [bll_pkg::VAL_W-1:0]  rev_left,
  input  logic [bll_pkg::VAL_W-1:0]  rev_right,
  input  logic [bll_pkg::VAL_W-1:0]  rev_head,
  output logic [bll_pkg::VAL_W-1:0]  fwd_q,
  output logic [bll_pkg::VAL_W-1:0]  rev_q
);

  localparam int CW = bll_pkg::CNT_W;
  localparam logic [CW-1:0] ME = CW'(POS);

  logic [bll_pkg::VAL_W-1:0] fwd_r, fwd_nxt;
  logic [bll_pkg::VAL_W-1:0] rev_r, rev_nxt;

  always_comb begin
    fwd_nxt = fwd_r;
    rev_nxt = rev_r;
    case (ctrl.kind)
      bll_pkg::CELL_PUSH_FRONT: begin
        fwd_nxt = (ME == '0) ? ctrl.value : fwd_left;
        if (ME == ctrl.wr_idx) rev_nxt = ctrl.value;
      end
      bll_pkg::CELL_PUSH_BACK: begin
        if (ME == ctrl.wr_idx) fwd_nxt = ctrl.value;
        rev_nxt = (ME == '0) ? ctrl.value : rev_left;
      end
      bll_pkg::CELL_REMOVE: begin
        if (ME >= ctrl.rm_fwd) fwd_nxt = fwd_right;
        if (ME >= ctrl.rm_rev) rev_nxt = rev_right;
      end
      bll_pkg::CELL_ROTATE: begin
        fwd_nxt = (ME == ctrl.wrap) ? fwd_head : fwd_right;
        rev_nxt = (ME == ctrl.wrap) ? rev_head : rev_right;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    fwd_r <= fwd_nxt;
    rev_r <= rev_nxt;
  end

  assign fwd_q = fwd_r;
  assign rev_q = rev_r;

endmodule

### hdl/bounded_list_with_indexed_remove.sv
// Top level of the bounded list: control FSM plus a chain of DEPTH cells.
// Depends on bll_pkg and bll_cell.
//
// Usage:
//  - Input channel (in_*): one beat per operation. in_tuser is the opcode
//    (push front, push back, remove at position, no-op); in_tdata is the
//    value to push or the zero-based position to remove.
//  - Output channel (out_*): after every operation the whole list is sent,
//    one beat per element, front to back. Beat i carries element i from
//    the front and element i from the back. An empty list gives a single
//    beat with is_empty set and zero values. out_tlast marks the final beat.
//    The operation's status is repeated on every beat.
//  - Timing: the operation is applied in the accept cycle; output beats
//    start the next cycle. The list streams out of cell 0 one beat per
//    cycle while each beat is taken. in_tready is low while the list is
//    being sent.
//  - The chain keeps two copies, one in front order and one reversed, so
//    both values come from cell 0; each beat rotates both copies by one,
//    and after the final beat the list is back in place.
//  - Receiver stall: the chain holds until the beat is taken.
//  - Reset clears the count and the FSM; cell contents are not cleared,
//    as nothing past the count is ever read.
module bounded_list_with_indexed_remove #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,  // [31:0] operand
  input  logic [1:0]  in_tuser,  // [1:0] opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata, // [31:0] front_value, [63:32] back_value
  output logic [2:0]  out_tuser, // [0] is_empty, [2:1] status
  output logic        out_tlast
);

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PCW  = bll_pkg::CNT_W;
  localparam int VW   = bll_pkg::VAL_W;

  bll_pkg::state_t     state_r, state_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  bll_pkg::status_t    status_r, status_nxt;
  logic [IW-1:0]       idx_r;
  bll_pkg::cell_ctrl_t ctrl;

  logic in_fire, out_fire, is_last, list_empty, list_full, out_of_range;
  bll_pkg::opcode_t opcode;

  logic [VW-1:0] fwd_q [DEPTH];
  logic [VW-1:0] rev_q [DEPTH];

  assign opcode       = bll_pkg::opcode_t'(in_tuser);
  assign in_fire      = in_tvalid && in_tready;
  assign out_fire     = out_tvalid && out_tready;
  assign list_empty   = (count_r == '0);
  assign list_full    = (count_r == CW'(DEPTH));
  // unsigned compare: negative positions land here too
  assign out_of_range = (in_tdata >= 32'(count_r));
  assign is_last      = list_empty || (IW'(count_r - CW'(1)) == idx_r);

  // ---------------- next state ----------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bll_pkg::ST_IDLE: if (in_fire) state_nxt = bll_pkg::ST_EMIT;
      bll_pkg::ST_EMIT: if (out_fire && is_last) state_nxt = bll_pkg::ST_IDLE;
      default:          state_nxt = bll_pkg::ST_IDLE;
    endcase
  end

  // ---------------- outputs and cell control ----------------
  always_comb begin
    in_tready   = (state_r == bll_pkg::ST_IDLE);
    out_tvalid  = (state_r == bll_pkg::ST_EMIT);
    count_nxt   = count_r;
    status_nxt  = status_r;
    ctrl.kind   = bll_pkg::CELL_HOLD;
    ctrl.value  = in_tdata;
    ctrl.wr_idx = PCW'(count_r);
    ctrl.rm_fwd = in_tdata[PCW-1:0];
    ctrl.rm_rev = PCW'(count_r) - PCW'(1) - in_tdata[PCW-1:0];
    ctrl.wrap   = PCW'(count_r) - PCW'(1);

    if (in_fire) begin
      status_nxt = bll_pkg::STS_DONE;
      case (opcode)
        bll_pkg::OP_PUSH_FRONT, bll_pkg::OP_PUSH_BACK: begin
          if (list_full) begin
            status_nxt = bll_pkg::STS_FULL;
          end else begin
            ctrl.kind = (opcode == bll_pkg::OP_PUSH_FRONT) ?
                        bll_pkg::CELL_PUSH_FRONT : bll_pkg::CELL_PUSH_BACK;
            count_nxt = count_r + CW'(1);
          end
        end
        bll_pkg::OP_REMOVE: begin
          if (out_of_range) begin
            status_nxt = bll_pkg::STS_RANGE;
          end else begin
            ctrl.kind = bll_pkg::CELL_REMOVE;
            count_nxt = count_r - CW'(1);
          end
        end
        default: ;
      endcase
    end else if (out_fire && !list_empty) begin
      ctrl.kind = bll_pkg::CELL_ROTATE;
    end

    out_tdata = list_empty ? '0 : {rev_q[0], fwd_q[0]};
    out_tuser = {status_r, list_empty};
    out_tlast = is_last;
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= bll_pkg::ST_IDLE;
      count_r  <= '0;
      status_r <= bll_pkg::STS_DONE;
      idx_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      status_r <= status_nxt;
      if (in_fire)       idx_r <= '0;
      else if (out_fire) idx_r <= idx_r + IW'(1);
    end
  end

  // ---------------- cell chain ----------------
  for (genvar j = 0; j < DEPTH; j++) begin : g_cell
    logic [VW-1:0] fl, fr, rl, rr;
    if (j == 0) begin : g_first
      assign fl = ctrl.value;
      assign rl = ctrl.value;
    end else begin : g_mid
      assign fl = fwd_q[j-1];
      assign rl = rev_q[j-1];
    end
    if (j == DEPTH - 1) begin : g_end
      assign fr = fwd_q[j];
      assign rr = rev_q[j];
    end else begin : g_inner
      assign fr = fwd_q[j+1];
      assign rr = rev_q[j+1];
    end

    bll_cell #(.POS(j)) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .fwd_left  (fl),
      .fwd_right (fr),
      .fwd_head  (fwd_q[0]),
      .rev_left  (rl),
      .rev_right (rr),
      .rev_head  (rev_q[0]),
      .fwd_q     (fwd_q[j]),
      .rev_q     (rev_q[j])
    );
  end

  // ---------------- assertions ----------------
  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input and output sides active together");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("element count above DEPTH");

  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && list_full &&
    (opcode == bll_pkg::OP_PUSH_FRONT || opcode == bll_pkg::OP_PUSH_BACK)
    |=> status_r == bll_pkg::STS_FULL && $stable(count_r))
    else $error("push onto full list not dropped");

  a_last_returns: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && out_tlast |=> in_tready)
    else $error("final beat did not return to idle");

  a_empty_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && list_empty |-> out_tlast)
    else $error("empty list run longer than one beat");

endmodule
